// ===== rtl/core/swk_pkg.sv =====
package swk_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int SPEED_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam int LANES         = 4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEVER_ARM = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RPM_GAIN  = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_LF = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_LB = 8'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_RF = 8'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_RB = 8'd5;

   localparam logic [CSR_DATA_BITS-1:0] LEVER_ARM_RST = 16'd10861;
   localparam logic [CSR_DATA_BITS-1:0] RPM_GAIN_RST  = 16'd774;
   localparam logic [ANGLE_BITS-1:0]    OFFSET_RST    = ANGLE_BITS'(61872);

   // CORDIC gain removal, Q16
   localparam logic signed [16:0] INV_GAIN_Q16 = 17'sd39797;

   // atan(2^-i) in 32-bit turns
   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

// ===== rtl/core/swk_ifs.sv =====
interface swk_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [swk_pkg::SPEED_BITS-1:0] vel_x;
   logic signed [swk_pkg::SPEED_BITS-1:0] vel_y;
   logic signed [swk_pkg::SPEED_BITS-1:0] yaw_rate;
   logic        [swk_pkg::ANGLE_BITS-1:0] turret_angle;
   logic        [swk_pkg::ANGLE_BITS-1:0] meas_steer_0;
   logic        [swk_pkg::ANGLE_BITS-1:0] meas_steer_1;
   logic        [swk_pkg::ANGLE_BITS-1:0] meas_steer_2;
   logic        [swk_pkg::ANGLE_BITS-1:0] meas_steer_3;
   modport source (output valid, vel_x, vel_y, yaw_rate, turret_angle,
                   meas_steer_0, meas_steer_1, meas_steer_2, meas_steer_3, input ready);
   modport sink (input valid, vel_x, vel_y, yaw_rate, turret_angle,
                 meas_steer_0, meas_steer_1, meas_steer_2, meas_steer_3, output ready);
endinterface

interface swk_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [swk_pkg::SPEED_BITS-1:0] drive_rpm_0;
   logic signed [swk_pkg::SPEED_BITS-1:0] drive_rpm_1;
   logic signed [swk_pkg::SPEED_BITS-1:0] drive_rpm_2;
   logic signed [swk_pkg::SPEED_BITS-1:0] drive_rpm_3;
   logic        [swk_pkg::ANGLE_BITS-1:0] steer_target_0;
   logic        [swk_pkg::ANGLE_BITS-1:0] steer_target_1;
   logic        [swk_pkg::ANGLE_BITS-1:0] steer_target_2;
   logic        [swk_pkg::ANGLE_BITS-1:0] steer_target_3;
   modport source (output valid, drive_rpm_0, drive_rpm_1, drive_rpm_2, drive_rpm_3,
                   steer_target_0, steer_target_1, steer_target_2, steer_target_3,
                   input ready);
   modport sink (input valid, drive_rpm_0, drive_rpm_1, drive_rpm_2, drive_rpm_3,
                 steer_target_0, steer_target_1, steer_target_2, steer_target_3,
                 output ready);
endinterface

interface swk_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [swk_pkg::CSR_IDX_BITS-1:0]     index;
   logic [swk_pkg::CSR_DATA_BITS-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/swerve_module_kinematics_unit.sv =====
// Four-module swerve inverse kinematics. Each item (turret-frame velocity command,
// turret angle, four measured steering angles) yields one result: drive rpm and
// steering target per module. The block takes one item per cycle while the result side
// does not stall. An item passes 2*CORDIC_STAGES+6 register stages, set by the turret
// rotation CORDIC and the per-module vectoring CORDIC, one register per iteration, in
// series. Its result is offered from the last stage. The four modules run in parallel
// lanes. Each stage stalls only when it and everything after it is full, so bubbles
// are squeezed out.
// Configuration writes are taken at any time and must only happen while idle.
module swerve_module_kinematics_unit (
   input  logic      clock,
   input  logic      reset,
   swk_req_if.sink   req_ch,
   swk_rsp_if.source rsp_ch,
   swk_csr_if.sink   csr_ch
);
   import swk_pkg::*;

   localparam int A    = ANGLE_BITS;
   localparam int SW   = SPEED_BITS;
   localparam int CS   = CORDIC_STAGES;
   localparam int RW   = SW + 11;   // rotator x/y
   localparam int RPW  = RW + 17;   // rotator gain product
   localparam int CW   = SW + 12;   // chassis speed and wheel vector
   localparam int TPW  = SW + 17;   // yaw * lever product
   localparam int TW   = TPW - 10;
   localparam int VW   = CW + 2;    // vectoring x/y
   localparam int MPW  = VW + 17;
   localparam int MW   = VW - 3;    // magnitude
   localparam int GPW  = MW + 16;   // magnitude * gain
   localparam int NST  = 2 * CS + 6;
   localparam int LAST = NST - 1;
   localparam int QUARTER = 1 << (A - 2);
   localparam logic [31:0] HEAD_RND = 32'(1) << (31 - A);
   localparam logic [LANES-1:0] BASE_NEG = 4'b1010;
   localparam logic [SW:0] SAT_LIM = (SW+1)'(1) << (SW - 1);

   typedef struct {
      logic signed [SW-1:0]  wz;
      logic [A-1:0]          meas  [LANES];
      logic signed [RW-1:0]  rx;
      logic signed [RW-1:0]  ry;
      logic signed [32:0]    rz;
      logic signed [TPW-1:0] tprod;
      logic signed [RPW-1:0] rxp;
      logic signed [RPW-1:0] ryp;
      logic signed [TW-1:0]  t;
      logic signed [VW-1:0]  vx    [LANES];
      logic signed [VW-1:0]  vy    [LANES];
      logic [31:0]           vz    [LANES];
      logic                  zero  [LANES];
      logic signed [MPW-1:0] magp  [LANES];
      logic [A-1:0]          steer [LANES];
      logic                  neg   [LANES];
      logic [GPW-1:0]        gainp [LANES];
      logic [SW-1:0]         drive [LANES];
   } ctx_type;

   logic [CSR_DATA_BITS-1:0] lever_ff;
   logic [CSR_DATA_BITS-1:0] gain_ff;
   logic [A-1:0]             offset_ff [LANES];

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] en;
   ctx_type        pipe_ff [NST];
   ctx_type        nxt     [NST];

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lever_ff <= LEVER_ARM_RST;
         gain_ff  <= RPM_GAIN_RST;
         for (int k = 0; k < LANES; k++) offset_ff[k] <= OFFSET_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LEVER_ARM: lever_ff     <= csr_ch.data;
            CSR_RPM_GAIN:  gain_ff      <= csr_ch.data;
            CSR_OFFSET_LF: offset_ff[0] <= A'(csr_ch.data);
            CSR_OFFSET_LB: offset_ff[1] <= A'(csr_ch.data);
            CSR_OFFSET_RF: offset_ff[2] <= A'(csr_ch.data);
            CSR_OFFSET_RB: offset_ff[3] <= A'(csr_ch.data);
            default: ;
         endcase
      end
   end

   // stage stall chain: a stage advances when empty or when its successor advances
   always_comb begin
      en[LAST] = !vld_ff[LAST] || rsp_ch.ready;
      for (int s = LAST - 1; s >= 0; s--) en[s] = !vld_ff[s] || en[s+1];
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_ch.valid;
         for (int s = 1; s < NST; s++) begin
            if (en[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NST; s++) begin
         if (en[s]) pipe_ff[s] <= nxt[s];
      end
   end

   for (genvar g = 0; g < NST; g++) begin : g_stage
      ctx_type c;
      if (g == 0) begin : g_entry
         logic [31:0] ang;
         always_comb begin
            c = '{default: '0};
            c.wz      = req_ch.yaw_rate;
            c.meas[0] = req_ch.meas_steer_0;
            c.meas[1] = req_ch.meas_steer_1;
            c.meas[2] = req_ch.meas_steer_2;
            c.meas[3] = req_ch.meas_steer_3;
            c.rx = RW'($signed({req_ch.vel_x, 8'b0}));
            c.ry = RW'($signed({req_ch.vel_y, 8'b0}));
            ang  = {req_ch.turret_angle, {(32 - A){1'b0}}};
            // second and third quadrant: rotate by a half turn up front
            if (ang[31] ^ ang[30]) begin
               c.rx    = -c.rx;
               c.ry    = -c.ry;
               ang[31] = ~ang[31];
            end
            c.rz = 33'($signed(ang));
         end
      end else if (g <= CS) begin : g_rot
         localparam int I = g - 1;
         always_comb begin
            c = pipe_ff[g-1];
            if (!pipe_ff[g-1].rz[32]) begin
               c.rx = pipe_ff[g-1].rx - (pipe_ff[g-1].ry >>> I);
               c.ry = pipe_ff[g-1].ry + (pipe_ff[g-1].rx >>> I);
               c.rz = pipe_ff[g-1].rz - $signed({1'b0, ATAN_TURNS[I]});
            end else begin
               c.rx = pipe_ff[g-1].rx + (pipe_ff[g-1].ry >>> I);
               c.ry = pipe_ff[g-1].ry - (pipe_ff[g-1].rx >>> I);
               c.rz = pipe_ff[g-1].rz + $signed({1'b0, ATAN_TURNS[I]});
            end
            if (g == 1) c.tprod = pipe_ff[g-1].wz * $signed({1'b0, lever_ff});
         end
      end else if (g == CS + 1) begin : g_rgain
         always_comb begin
            c = pipe_ff[g-1];
            c.rxp = pipe_ff[g-1].rx * INV_GAIN_Q16;
            c.ryp = pipe_ff[g-1].ry * INV_GAIN_Q16;
            c.t   = TW'(pipe_ff[g-1].tprod >>> 10);
         end
      end else if (g == CS + 2) begin : g_wheel
         logic signed [CW-1:0] cx, cy, te;
         logic signed [CW-1:0] a [LANES];
         logic signed [CW-1:0] b [LANES];
         always_comb begin
            c  = pipe_ff[g-1];
            cx = CW'(pipe_ff[g-1].rxp >>> 16);
            cy = CW'(pipe_ff[g-1].ryp >>> 16);
            te = CW'(pipe_ff[g-1].t);
            for (int k = 0; k < LANES; k++) begin
               a[k] = (k >= 2) ? cx + te : cx - te;
               b[k] = (k % 2 == 0) ? cy + te : cy - te;
               c.zero[k] = (a[k] == '0) && (b[k] == '0);
               // fold the left half plane into the right one
               if (b[k] < 0) begin
                  c.vx[k] = -VW'(b[k]);
                  c.vy[k] = -VW'(a[k]);
                  c.vz[k] = 32'h8000_0000;
               end else begin
                  c.vx[k] = VW'(b[k]);
                  c.vy[k] = VW'(a[k]);
                  c.vz[k] = '0;
               end
            end
         end
      end else if (g <= 2 * CS + 2) begin : g_vec
         localparam int I = g - CS - 3;
         always_comb begin
            c = pipe_ff[g-1];
            for (int k = 0; k < LANES; k++) begin
               if (!pipe_ff[g-1].vy[k][VW-1]) begin
                  c.vx[k] = pipe_ff[g-1].vx[k] + (pipe_ff[g-1].vy[k] >>> I);
                  c.vy[k] = pipe_ff[g-1].vy[k] - (pipe_ff[g-1].vx[k] >>> I);
                  c.vz[k] = pipe_ff[g-1].vz[k] + ATAN_TURNS[I];
               end else begin
                  c.vx[k] = pipe_ff[g-1].vx[k] - (pipe_ff[g-1].vy[k] >>> I);
                  c.vy[k] = pipe_ff[g-1].vy[k] + (pipe_ff[g-1].vx[k] >>> I);
                  c.vz[k] = pipe_ff[g-1].vz[k] - ATAN_TURNS[I];
               end
            end
         end
      end else if (g == 2 * CS + 3) begin : g_steer
         logic [31:0]  hs   [LANES];
         logic [A-1:0] head [LANES];
         logic [A-1:0] st   [LANES];
         logic [A-1:0] er   [LANES];
         logic         flip [LANES];
         always_comb begin
            c = pipe_ff[g-1];
            for (int k = 0; k < LANES; k++) begin
               c.magp[k] = pipe_ff[g-1].vx[k] * INV_GAIN_Q16;
               hs[k]   = pipe_ff[g-1].vz[k] + HEAD_RND;
               head[k] = pipe_ff[g-1].zero[k] ? '0 : hs[k][31 -: A];
               st[k]   = head[k] + offset_ff[k];
               er[k]   = st[k] - pipe_ff[g-1].meas[k];
               // beyond a quarter turn: reverse the wheel instead
               flip[k] = (int'($signed(er[k])) > QUARTER) ||
                         (int'($signed(er[k])) < -QUARTER);
               c.steer[k] = {st[k][A-1] ^ flip[k], st[k][A-2:0]};
               c.neg[k]   = BASE_NEG[k] ^ flip[k];
            end
         end
      end else if (g == 2 * CS + 4) begin : g_gain
         always_comb begin
            c = pipe_ff[g-1];
            for (int k = 0; k < LANES; k++) begin
               c.gainp[k] = GPW'(pipe_ff[g-1].magp[k][16 +: MW]) * GPW'(gain_ff);
            end
         end
      end else begin : g_sat
         logic [GPW:0]  rsum [LANES];
         logic [SW:0]   sat  [LANES];
         always_comb begin
            c = pipe_ff[g-1];
            for (int k = 0; k < LANES; k++) begin
               rsum[k] = {1'b0, pipe_ff[g-1].gainp[k]} + (GPW+1)'(32768);
               sat[k]  = (rsum[k][GPW:16] > (GPW-15)'(SAT_LIM)) ? SAT_LIM
                                                                 : rsum[k][16 +: SW+1];
               if (pipe_ff[g-1].neg[k]) begin
                  c.drive[k] = SW'(-sat[k]);
               end else if (sat[k] == SAT_LIM) begin
                  c.drive[k] = SW'(SAT_LIM - (SW+1)'(1));
               end else begin
                  c.drive[k] = sat[k][SW-1:0];
               end
            end
         end
      end
      assign nxt[g] = c;
   end

   assign rsp_ch.valid          = vld_ff[LAST];
   assign rsp_ch.drive_rpm_0    = pipe_ff[LAST].drive[0];
   assign rsp_ch.drive_rpm_1    = pipe_ff[LAST].drive[1];
   assign rsp_ch.drive_rpm_2    = pipe_ff[LAST].drive[2];
   assign rsp_ch.drive_rpm_3    = pipe_ff[LAST].drive[3];
   assign rsp_ch.steer_target_0 = pipe_ff[LAST].steer[0];
   assign rsp_ch.steer_target_1 = pipe_ff[LAST].steer[1];
   assign rsp_ch.steer_target_2 = pipe_ff[LAST].steer[2];
   assign rsp_ch.steer_target_3 = pipe_ff[LAST].steer[3];

`ifndef SYNTH
   a_entry_fill: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted item did not enter the first stage");

   a_zero_drive: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && pipe_ff[LAST].zero[0] |-> rsp_ch.drive_rpm_0 == '0)
      else $error("zero wheel vector gave nonzero drive");

   a_drive_sign: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !pipe_ff[LAST].neg[0] |-> !rsp_ch.drive_rpm_0[SW-1])
      else $error("forward drive came out negative");
`endif

endmodule

// ===== bench/swk_kin_checker.sv =====
module swk_kin_checker (
   input  logic      clock,
   input  logic      reset,
   swk_req_if.sink   req_mon,
   swk_rsp_if.sink   rsp_mon,
   swk_csr_if.sink   csr_mon,
   output int        fail_count,
   output int        pending_count,
   output int        ticks_seen,
   output int        flips_seen,
   output int        sats_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import swk_pkg::*;

   typedef struct packed {
      logic signed [SPEED_BITS-1:0] rpm0, rpm1, rpm2, rpm3;
      logic [ANGLE_BITS-1:0]        st0, st1, st2, st3;
   } wheel_cmd_type;

   logic [15:0]    lever_q8, gain_q8;
   logic [15:0]    offset_mem [LANES];
   wheel_cmd_type  cmd_queue [$];

   function automatic longint fshr(longint v, int n);
      return v >>> n;
   endfunction

   task automatic solve_tick(input logic signed [15:0] vx, vy, wz, input logic [15:0] turret,
                             input logic [15:0] meas [LANES], output wheel_cmd_type cmd);
      longint x, y, z, nx, t, wa, wb, mag, err, rpm;
      logic [31:0] ang, zw;
      logic [15:0] head, steer;
      logic signed [15:0] rpm_o [LANES];
      logic [15:0] st_o [LANES];
      int sgn;
      x = longint'(vx) * 256;
      y = longint'(vy) * 256;
      ang = {turret, 16'h0};
      if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
         x = -x; y = -y; ang = ang - 32'h80000000;
      end
      z = longint'($signed(ang));
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - fshr(y, i); y = y + fshr(x, i); z -= longint'(ATAN_TURNS[i]);
         end else begin
            nx = x + fshr(y, i); y = y - fshr(x, i); z += longint'(ATAN_TURNS[i]);
         end
         x = nx;
      end
      x = fshr(x * 39797, 16);
      y = fshr(y * 39797, 16);
      t = fshr(longint'(wz) * longint'(lever_q8), 10);
      for (int k = 0; k < LANES; k++) begin
         wa = (k < 2) ? x - t : x + t;
         wb = (k % 2 == 0) ? y + t : y - t;
         if (wa == 0 && wb == 0) begin
            zw = 0; mag = 0;
         end else begin
            longint cx, cy, cz;
            cx = wb; cy = wa; cz = 0;
            if (cx < 0) begin
               cx = -cx; cy = -cy; cz = 64'h80000000;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
               if (cy >= 0) begin
                  nx = cx + fshr(cy, i); cy = cy - fshr(cx, i); cz += longint'(ATAN_TURNS[i]);
               end else begin
                  nx = cx - fshr(cy, i); cy = cy + fshr(cx, i); cz -= longint'(ATAN_TURNS[i]);
               end
               cx = nx;
            end
            zw = cz[31:0];
            mag = fshr(cx * 39797, 16);
         end
         head = 16'((33'(zw) + 33'h8000) >> 16);
         steer = head + offset_mem[k];
         err = longint'($signed(16'(steer - meas[k])));
         sgn = (k % 2 == 0) ? 1 : -1;
         if (err > 16384 || err < -16384) begin
            sgn = -sgn; steer = steer + 16'h8000; flips_seen++;
         end
         rpm = (mag * longint'(gain_q8) + 32768) >>> 16;
         if (rpm > 32768) rpm = 32768;
         if (sgn < 0) rpm = -rpm;
         if (rpm > 32767) rpm = 32767;
         if (rpm == 32767 || rpm == -32768) sats_seen++;
         rpm_o[k] = 16'(rpm);
         st_o[k] = steer;
      end
      cmd = '{rpm_o[0], rpm_o[1], rpm_o[2], rpm_o[3], st_o[0], st_o[1], st_o[2], st_o[3]};
   endtask

   task automatic cmp(input string name, input logic [15:0] e, a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      wheel_cmd_type c, w;
      logic [15:0] m [LANES];
      if (reset) begin
         lever_q8 <= LEVER_ARM_RST;
         gain_q8 <= RPM_GAIN_RST;
         for (int k = 0; k < LANES; k++) offset_mem[k] <= OFFSET_RST;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_LEVER_ARM: lever_q8 <= csr_mon.data;
               CSR_RPM_GAIN: gain_q8 <= csr_mon.data;
               CSR_OFFSET_LF: offset_mem[0] <= csr_mon.data;
               CSR_OFFSET_LB: offset_mem[1] <= csr_mon.data;
               CSR_OFFSET_RF: offset_mem[2] <= csr_mon.data;
               CSR_OFFSET_RB: offset_mem[3] <= csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            w = '{rsp_mon.drive_rpm_0, rsp_mon.drive_rpm_1, rsp_mon.drive_rpm_2,
                  rsp_mon.drive_rpm_3, rsp_mon.steer_target_0, rsp_mon.steer_target_1,
                  rsp_mon.steer_target_2, rsp_mon.steer_target_3};
            if (cmd_queue.size() == 0) begin
               $error("result with no item pending");
               fail_count++;
            end else begin
               c = cmd_queue.pop_front();
               cmp("drive_rpm_0", c.rpm0, w.rpm0);
               cmp("drive_rpm_1", c.rpm1, w.rpm1);
               cmp("drive_rpm_2", c.rpm2, w.rpm2);
               cmp("drive_rpm_3", c.rpm3, w.rpm3);
               cmp("steer_target_0", c.st0, w.st0);
               cmp("steer_target_1", c.st1, w.st1);
               cmp("steer_target_2", c.st2, w.st2);
               cmp("steer_target_3", c.st3, w.st3);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            m = '{req_mon.meas_steer_0, req_mon.meas_steer_1, req_mon.meas_steer_2,
                  req_mon.meas_steer_3};
            solve_tick(req_mon.vel_x, req_mon.vel_y, req_mon.yaw_rate, req_mon.turret_angle,
                       m, c);
            cmd_queue.push_back(c);
            ticks_seen++;
         end
      end
      pending_count = cmd_queue.size();
   end

   initial begin
      fail_count = 0; pending_count = 0; ticks_seen = 0; flips_seen = 0; sats_seen = 0;
   end
endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swk_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, ticks_seen, flips_seen, sats_seen;
   int   send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
   int   sent_count = 0;

   swk_req_if req_ch();
   swk_rsp_if rsp_ch();
   swk_csr_if csr_ch();

   swerve_module_kinematics_unit u_top (.clock, .reset, .req_ch, .rsp_ch, .csr_ch);

   swk_kin_checker u_chk (.clock, .reset, .req_mon(req_ch), .rsp_mon(rsp_ch),
                          .csr_mon(csr_ch), .fail_count, .pending_count, .ticks_seen,
                          .flips_seen, .sats_seen);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall, or a counted long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_tick(input logic [15:0] vx, vy, wz, tu, m0, m1, m2, m3);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vel_x <= vx;
      req_ch.vel_y <= vy;
      req_ch.yaw_rate <= wz;
      req_ch.turret_angle <= tu;
      req_ch.meas_steer_0 <= m0;
      req_ch.meas_steer_1 <= m1;
      req_ch.meas_steer_2 <= m2;
      req_ch.meas_steer_3 <= m3;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   function automatic logic [15:0] rnd_speed();
      case ($urandom_range(5))
         0: return 16'($signed($urandom_range(64)) - 32);
         1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         2: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_ticks(input int n);
      logic [15:0] tu, base;
      for (int i = 0; i < n; i++) begin
         tu = $urandom_range(3) == 0 ? 16'($urandom_range(3) * 16384) : 16'($urandom);
         base = 16'($urandom);
         // cluster measured angles near a flip boundary now and then
         send_tick(rnd_speed(), rnd_speed(), $urandom_range(2) == 0 ? 16'd0 : rnd_speed(),
                   tu, $urandom_range(1) ? base : 16'($urandom),
                   base + 16'($urandom_range(8)) - 16'd4 + 16'h4000,
                   16'($urandom), base ^ 16'h8000);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.vel_x = '0; req_ch.vel_y = '0; req_ch.yaw_rate = '0; req_ch.turret_angle = '0;
      req_ch.meas_steer_0 = '0; req_ch.meas_steer_1 = '0;
      req_ch.meas_steer_2 = '0; req_ch.meas_steer_3 = '0;
      rsp_ch.ready = 1'b1;
      csr_ch.valid = 1'b0; csr_ch.index = '0; csr_ch.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero command, extremes, quarter-turn edges, turret quadrants
      send_tick(0, 0, 0, 0, 0, 0, 0, 0);
      send_tick(0, 0, 0, 0, 16'd61872 + 16'h4000, 16'd61872 - 16'h4000,
                16'd61872 + 16'h4001, 16'd61872 - 16'h4001);
      send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 16'h8000, 16'h4000, 16'hC000);
      send_tick(16'h8000, 16'h7FFF, 0, 16'h4000, 16'h1234, 0, 0, 0);
      send_tick(100, 0, 0, 16'hC000, 0, 0, 0, 0);
      send_tick(0, 100, 0, 16'h3FFF, 0, 0, 0, 0);
      send_tick(0, 0, 1000, 0, 0, 0, 0, 0);
      send_tick(0, 0, 16'hFC18, 16'h2000, 0, 0, 0, 0);
      send_tick(16'hFFFF, 1, 16'h0001, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0);
      idle_sender();
      drain();

      // register extremes
      csr_write(CSR_LEVER_ARM, 16'hFFFF);
      csr_write(CSR_RPM_GAIN, 16'hFFFF);
      csr_write(CSR_OFFSET_LF, 16'h0000);
      csr_write(CSR_OFFSET_LB, 16'hFFFF);
      csr_write(CSR_OFFSET_RF, 16'h8000);
      csr_write(CSR_OFFSET_RB, 16'h4000);
      csr_write(8'd77, 16'h1234);
      send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0);
      send_tick(0, 0, 0, 0, 16'h4000, 16'hBFFF, 16'hC000, 16'h0000);
      send_tick(1, 0, 16'h8000, 16'h1000, 0, 0, 0, 0);
      idle_sender();
      drain();
      csr_write(CSR_LEVER_ARM, 16'h0000);
      csr_write(CSR_RPM_GAIN, 16'h0000);
      send_tick(300, 400, 16'h7FFF, 0, 0, 0, 0, 0);
      idle_sender();
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(CSR_LEVER_ARM, ph == 0 ? LEVER_ARM_RST : 16'($urandom));
         csr_write(CSR_RPM_GAIN, ph == 0 ? RPM_GAIN_RST : 16'($urandom));
         for (int k = 0; k < LANES; k++)
            csr_write(CSR_OFFSET_LF + CSR_IDX_BITS'(k), 16'($urandom));
         send_idle_pct = ph == 1 || ph == 3 ? (ph == 1 ? 85 : 38) : 0;
         recv_stall_pct = ph == 2 ? 85 : (ph == 3 ? 38 : 0);
         if (ph == 0) begin
            hold_cycles = 300;
            random_ticks(60);
         end
         random_ticks(350);
         idle_sender();
         drain();
      end

      $display("covered %0d ticks (%0d sent), %0d steering reversals, %0d saturated drives",
               ticks_seen, sent_count, flips_seen, sats_seen);
      $display("registers written at extremes and random settings over four pacing phases");
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #3ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
